// File: sv/cmp_pkg.sv
// Shared types, widths and constants for the YUV color matrix projection.
// No dependencies.
package cmp_pkg;

    localparam int COEF_BITS  = 18;
    localparam int CFG_W      = 3 * COEF_BITS;
    localparam int CFG_IDX_W  = 2;
    localparam int SAMPLE_W   = 10;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int PROD_W     = DIFF_W + COEF_BITS;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_MASK  = (2 ** FRAC_BITS) - 1;
    localparam int RES_W      = SUM_W - FRAC_BITS + 1;
    localparam int PIPE_DEPTH = 4;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic [SAMPLE_W-1:0] OFF8  = SAMPLE_W'(128);
    localparam logic [SAMPLE_W-1:0] OFF10 = SAMPLE_W'(512);
    localparam logic [SAMPLE_W-1:0] MAX8  = SAMPLE_W'(255);
    localparam logic [SAMPLE_W-1:0] MAX10 = SAMPLE_W'(1023);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_MODE = 2'd0,
        REG_LUMA_COEFS = 2'd1,
        REG_U_COEFS    = 2'd2,
        REG_V_COEFS    = 2'd3
    } cfg_reg_t;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [DIFF_W-1:0]    diff_t;
    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [RES_W-1:0]     res_t;

    typedef struct packed {
        logic           depth_mode;
        coef_t [2:0]    luma;
        coef_t [2:0]    u;
        coef_t [2:0]    v;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_a;
        logic [SAMPLE_W-1:0] luma_b;
        logic [SAMPLE_W-1:0] luma_c;
        logic [SAMPLE_W-1:0] luma_d;
        logic [SAMPLE_W-1:0] chroma_u;
        logic [SAMPLE_W-1:0] chroma_v;
    } in_word_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_a_out;
        logic [SAMPLE_W-1:0] luma_b_out;
        logic [SAMPLE_W-1:0] luma_c_out;
        logic [SAMPLE_W-1:0] luma_d_out;
        logic [SAMPLE_W-1:0] chroma_u_out;
        logic [SAMPLE_W-1:0] chroma_v_out;
    } out_word_t;

    typedef struct packed {
        prod_t [3:0] luma_y;
        prod_t       luma_u;
        prod_t       luma_v;
        prod_t       u_y;
        prod_t       u_u;
        prod_t       u_v;
        prod_t       v_y;
        prod_t       v_u;
        prod_t       v_v;
    } prod_word_t;

    function automatic logic [SAMPLE_W-1:0] chroma_offset(logic depth_mode);
        return depth_mode ? OFF10 : OFF8;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_max(logic depth_mode);
        return depth_mode ? MAX10 : MAX8;
    endfunction

endpackage

// File: sv/cmp_in_if.sv
// Input channel: valid/ready handshake carrying one luma group and chroma pair.
// Depends on cmp_pkg.
interface cmp_in_if import cmp_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/cmp_out_if.sv
// Output channel: valid/ready handshake carrying the six projected samples.
// Depends on cmp_pkg.
interface cmp_out_if import cmp_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/cmp_cfg_regs.sv
// Configuration register file: depth mode and the three coefficient rows.
// Depends on cmp_pkg.
module cmp_cfg_regs import cmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEPTH_MODE: cfg_next.depth_mode = cfg_data[0];
                REG_LUMA_COEFS: cfg_next.luma = cfg_data;
                REG_U_COEFS:    cfg_next.u = cfg_data;
                REG_V_COEFS:    cfg_next.v = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/cmp_product.sv
// Stages 1-2: operand register (chroma offset removed), then the twelve products.
// Depends on cmp_pkg.
module cmp_product import cmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       up_valid,
    output logic       up_ready,
    input  in_word_t   up_data,
    output logic       down_valid,
    input  logic       down_ready,
    output prod_word_t down_data
);

    logic       a_valid_reg;
    logic       a_valid_next;
    diff_t      a_y_reg [4];
    diff_t      a_y_next [4];
    diff_t      a_du_reg;
    diff_t      a_du_next;
    diff_t      a_dv_reg;
    diff_t      a_dv_next;
    logic       a_ready;

    logic       b_valid_reg;
    logic       b_valid_next;
    prod_word_t b_data_reg;
    prod_word_t b_data_next;
    logic       b_ready;

    logic [SAMPLE_W-1:0] off;

    assign b_ready  = !b_valid_reg || down_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign off      = chroma_offset(cfg.depth_mode);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_y_next     = a_y_reg;
        a_du_next    = a_du_reg;
        a_dv_next    = a_dv_reg;
        if (a_ready)
        begin
            a_valid_next = up_valid;
            a_y_next[0]  = diff_t'({1'b0, up_data.luma_a});
            a_y_next[1]  = diff_t'({1'b0, up_data.luma_b});
            a_y_next[2]  = diff_t'({1'b0, up_data.luma_c});
            a_y_next[3]  = diff_t'({1'b0, up_data.luma_d});
            a_du_next    = diff_t'({1'b0, up_data.chroma_u}) - diff_t'({1'b0, off});
            a_dv_next    = diff_t'({1'b0, up_data.chroma_v}) - diff_t'({1'b0, off});
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_data_next  = b_data_reg;
        if (b_ready)
        begin
            b_valid_next = a_valid_reg;
            for (int i = 0; i < 4; i++)
            begin
                b_data_next.luma_y[i] = prod_t'(a_y_reg[i]) * prod_t'(cfg.luma[0]);
            end
            b_data_next.luma_u = prod_t'(a_du_reg) * prod_t'(cfg.luma[1]);
            b_data_next.luma_v = prod_t'(a_dv_reg) * prod_t'(cfg.luma[2]);
            b_data_next.u_y    = prod_t'(a_y_reg[0]) * prod_t'(cfg.u[0]);
            b_data_next.u_u    = prod_t'(a_du_reg) * prod_t'(cfg.u[1]);
            b_data_next.u_v    = prod_t'(a_dv_reg) * prod_t'(cfg.u[2]);
            b_data_next.v_y    = prod_t'(a_y_reg[0]) * prod_t'(cfg.v[0]);
            b_data_next.v_u    = prod_t'(a_du_reg) * prod_t'(cfg.v[1]);
            b_data_next.v_v    = prod_t'(a_dv_reg) * prod_t'(cfg.v[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_y_reg    <= a_y_next;
        a_du_reg   <= a_du_next;
        a_dv_reg   <= a_dv_next;
        b_data_reg <= b_data_next;
    end

    assign down_valid = b_valid_reg;
    assign down_data  = b_data_reg;

endmodule

// File: sv/cmp_sum_clip.sv
// Stages 3-4: row sums, then divide by 65536 toward zero, restore offset, clip.
// Depends on cmp_pkg.
module cmp_sum_clip import cmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       up_valid,
    output logic       up_ready,
    input  prod_word_t up_data,
    output logic       down_valid,
    input  logic       down_ready,
    output out_word_t  down_data
);

    logic      c_valid_reg;
    logic      c_valid_next;
    sum_t      c_luma_reg [4];
    sum_t      c_luma_next [4];
    sum_t      c_u_reg;
    sum_t      c_u_next;
    sum_t      c_v_reg;
    sum_t      c_v_next;
    logic      c_ready;

    logic      d_valid_reg;
    logic      d_valid_next;
    out_word_t d_data_reg;
    out_word_t d_data_next;
    logic      d_ready;

    function automatic logic [SAMPLE_W-1:0] scale_clip(sum_t s, logic add_off, logic depth);
        sum_t biased;
        res_t r;
        res_t maxv;
        biased = s + (s[SUM_W-1] ? sum_t'(FRAC_MASK) : sum_t'(0));
        r      = res_t'(biased >>> FRAC_BITS);
        if (add_off)
        begin
            r = r + res_t'(chroma_offset(depth));
        end
        maxv = res_t'(sample_max(depth));
        if (r < 0)
        begin
            return '0;
        end
        else if (r > maxv)
        begin
            return maxv[SAMPLE_W-1:0];
        end
        return r[SAMPLE_W-1:0];
    endfunction

    assign d_ready  = !d_valid_reg || down_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign up_ready = c_ready;

    always_comb
    begin
        c_valid_next = c_valid_reg;
        c_luma_next  = c_luma_reg;
        c_u_next     = c_u_reg;
        c_v_next     = c_v_reg;
        if (c_ready)
        begin
            c_valid_next = up_valid;
            for (int i = 0; i < 4; i++)
            begin
                c_luma_next[i] = sum_t'(up_data.luma_y[i]) + sum_t'(up_data.luma_u)
                               + sum_t'(up_data.luma_v);
            end
            c_u_next = sum_t'(up_data.u_y) + sum_t'(up_data.u_u) + sum_t'(up_data.u_v);
            c_v_next = sum_t'(up_data.v_y) + sum_t'(up_data.v_u) + sum_t'(up_data.v_v);
        end
    end

    always_comb
    begin
        d_valid_next = d_valid_reg;
        d_data_next  = d_data_reg;
        if (d_ready)
        begin
            d_valid_next             = c_valid_reg;
            d_data_next.luma_a_out   = scale_clip(c_luma_reg[0], 1'b0, cfg.depth_mode);
            d_data_next.luma_b_out   = scale_clip(c_luma_reg[1], 1'b0, cfg.depth_mode);
            d_data_next.luma_c_out   = scale_clip(c_luma_reg[2], 1'b0, cfg.depth_mode);
            d_data_next.luma_d_out   = scale_clip(c_luma_reg[3], 1'b0, cfg.depth_mode);
            d_data_next.chroma_u_out = scale_clip(c_u_reg, 1'b1, cfg.depth_mode);
            d_data_next.chroma_v_out = scale_clip(c_v_reg, 1'b1, cfg.depth_mode);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_luma_reg <= c_luma_next;
        c_u_reg    <= c_u_next;
        c_v_reg    <= c_v_next;
        d_data_reg <= d_data_next;
    end

    assign down_valid = d_valid_reg;
    assign down_data  = d_data_reg;

endmodule

// File: sv/yuv_color_matrix_projection.sv
// Top level of the YUV 3x3 color matrix projection pipeline.
// Depends on cmp_pkg, cmp_in_if, cmp_out_if, cmp_cfg_regs, cmp_product, cmp_sum_clip.
//
// Usage:
//   sample: one word per group: four luma samples and the shared U/V pair.
//   result: one word per input word: four projected luma samples and the
//           projected U and V with the chroma offset restored, all clipped
//           to 0..255 (depth_mode 0) or 0..1023 (depth_mode 1).
//   cfg_we/cfg_index/cfg_data: register writes (0 depth mode, 1 luma row,
//           2 U row, 3 V row); write only while no word is in flight.
//   A sample word passes four registers in order: operand, multiplier,
//   row-sum and clip/output; result valid is driven by the last of them.
//   Throughput is one word per cycle while result.ready stays high; each stage holds one word.
//   Reset clears all stage valids and the config registers to zero; the data registers are not reset.
//   When result.ready is low the output register holds its word; earlier
//   stages keep filling until every stage is occupied, then sample.ready
//   drops. No word is lost or repeated.
module yuv_color_matrix_projection import cmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cmp_in_if.sink               sample,
    cmp_out_if.source            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t       cfg;
    logic       prod_valid;
    logic       prod_ready;
    prod_word_t prod_data;

    cmp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmp_product u_product (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (sample.valid),
        .up_ready   (sample.ready),
        .up_data    (sample.data),
        .down_valid (prod_valid),
        .down_ready (prod_ready),
        .down_data  (prod_data)
    );

    cmp_sum_clip u_sum_clip (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (prod_valid),
        .up_ready   (prod_ready),
        .up_data    (prod_data),
        .down_valid (result.valid),
        .down_ready (result.ready),
        .down_data  (result.data)
    );

endmodule

// File: sv/cmp_checker.sv
// Port-level checks for the projection pipeline, bound to the top level.
// Depends on cmp_pkg and yuv_color_matrix_projection.
module cmp_checker import cmp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      sample_valid,
    input logic      sample_ready,
    input logic      result_valid,
    input logic      result_ready,
    input out_word_t result_data
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = sample_valid && sample_ready;
    assign out_acc = result_valid && result_ready;

    always_comb
    begin
        count_next = count_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result word changed while stalled");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> !result_valid)
        else $error("result valid with no word in flight");

    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> sample_ready)
        else $error("input stalled while output drains");

endmodule

bind yuv_color_matrix_projection cmp_checker u_cmp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
